// ----- hw/rtl/ecl_pkg.sv -----
// ----------------------------------------------------------------------------
// ecl_pkg
// Shared types and constants of the polygon ear test block.
// ----------------------------------------------------------------------------
package ecl_pkg;

  // fixed field widths of the stream items
  localparam int unsigned IDX_W = 8;  // slot, list_vertex and the corner positions
  localparam int unsigned LEN_W = 9;  // list_length
  localparam int unsigned OUT_W = 8;  // result tdata, is_ear padded to a byte

  typedef enum logic [1:0] {
    MODE_VTX   = 2'd0,
    MODE_LIST  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_HOLD
  } state_e;

  // what a read issued into the scan pipeline stands for
  typedef enum logic [2:0] {
    K_CORNER_A,
    K_CORNER_B,
    K_CORNER_C,
    K_AREA,
    K_POINT
  } kind_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
    logic  skip;
    logic  last;
  } tag_t;

  typedef struct packed {
    logic ge0;
    logic gt0;
  } cross_flags_t;

endpackage

// ----- hw/rtl/ecl_cross.sv -----
// ----------------------------------------------------------------------------
// ecl_cross
// Pipelined sign of p*q - r*s: operand, product and flag registers.
// ----------------------------------------------------------------------------
module ecl_cross #(
  parameter int unsigned DW = 25
) (
  input  logic                    clk_i,
  input  logic signed [DW-1:0]    p_i,
  input  logic signed [DW-1:0]    q_i,
  input  logic signed [DW-1:0]    r_i,
  input  logic signed [DW-1:0]    s_i,
  output ecl_pkg::cross_flags_t   flags_o
);

  logic signed [DW-1:0]   p_q, q_q, r_q, s_q;
  logic signed [2*DW-1:0] m1_q, m2_q;
  logic        [2*DW:0]   diff;
  ecl_pkg::cross_flags_t  flags_d, flags_q;

  // exact difference, one extra bit so it cannot wrap
  assign diff = {m1_q[2*DW-1], m1_q} - {m2_q[2*DW-1], m2_q};

  always_comb begin
    flags_d.ge0 = ~diff[2*DW];
    flags_d.gt0 = ~diff[2*DW] && (diff != '0);
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_i;
    q_q     <= q_i;
    r_q     <= r_i;
    s_q     <= s_i;
    m1_q    <= p_q * q_q;
    m2_q    <= r_q * s_q;
    flags_q <= flags_d;
  end

  assign flags_o = flags_q;

endmodule

// ----- hw/rtl/ecl_store.sv -----
// ----------------------------------------------------------------------------
// ecl_store
// Active list and vertex memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module ecl_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned CW    = 24
) (
  input  logic            clk_i,
  input  logic            list_we_i,
  input  logic [AW-1:0]   list_waddr_i,
  input  logic [AW-1:0]   list_wdata_i,
  input  logic [AW-1:0]   list_raddr_i,
  output logic [AW-1:0]   list_rdata_o,
  input  logic            vtx_we_i,
  input  logic [AW-1:0]   vtx_waddr_i,
  input  logic [2*CW-1:0] vtx_wdata_i,
  input  logic [AW-1:0]   vtx_raddr_i,
  output logic [2*CW-1:0] vtx_rdata_o
);

  logic [AW-1:0]   list_mem [DEPTH];
  logic [2*CW-1:0] vtx_mem  [DEPTH];
  logic [AW-1:0]   list_rdata_q;
  logic [2*CW-1:0] vtx_rdata_q;

  // writes come only from idle load items; reads run every cycle, used only during a query
  always_ff @(posedge clk_i) begin
    if (list_we_i) begin
      list_mem[list_waddr_i] <= list_wdata_i;
    end
    list_rdata_q <= list_mem[list_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (vtx_we_i) begin
      vtx_mem[vtx_waddr_i] <= vtx_wdata_i;
    end
    vtx_rdata_q <= vtx_mem[vtx_raddr_i];
  end

  assign list_rdata_o = list_rdata_q;
  assign vtx_rdata_o  = vtx_rdata_q;

endmodule

// ----- hw/rtl/polygon_ear_test_top.sv -----
// ----------------------------------------------------------------------------
// polygon_ear_test_top
// Ear test for ear-clipping triangulation over a vertex memory and an
// active vertex list.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel, tuser carrying the mode. A vertex
// item writes (x, y) into the vertex memory and a list item writes one active
// list entry; neither gives a result. A query item names three list positions
// and a scan length; its single result leaves on m_axis, bit 0 of tdata is
// is_ear.
// A query reads the three corners, one area check and then one list entry per
// cycle through list read, vertex read and a three stage cross product pipeline
// (three units of two multipliers each). The scan runs over list_length entries,
// clipped to MAX_VERTICES, through the list and vertex read ports.
// s_axis_tready_o is low while a query runs; load items are taken back to back.
// The result sits in an output register: a stalled receiver does not block new
// load items or the next query, which only waits at its end if the register is
// still full. Reset clears the control state; memory contents are undefined
// until written, and no clearing pass runs.
// ----------------------------------------------------------------------------
module polygon_ear_test_top #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned COORD_BITS   = 24,
  localparam int unsigned IN_BITS     = 5 * ecl_pkg::IDX_W + ecl_pkg::LEN_W
                                        + 2 * COORD_BITS,
  localparam int unsigned IN_W        = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // slot, coord_x, coord_y, list_vertex, corner_a, corner_b, corner_c, list_length
  input  logic [IN_W-1:0]            s_axis_tdata_i,
  // mode
  input  logic [1:0]                 s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // is_ear
  output logic [ecl_pkg::OUT_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned AW    = $clog2(MAX_VERTICES);
  localparam int unsigned PW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned IW    = ecl_pkg::IDX_W;
  localparam int unsigned NSTG  = 5;
  localparam int unsigned WRAP_SHIFT = 16;
  localparam int unsigned WRAP_RECIP = (1 << WRAP_SHIFT) / MAX_VERTICES;

  localparam int unsigned SLOT_LSB = 0;
  localparam int unsigned CX_LSB   = IW;
  localparam int unsigned CY_LSB   = CX_LSB + CB;
  localparam int unsigned LV_LSB   = CY_LSB + CB;
  localparam int unsigned CA_LSB   = LV_LSB + IW;
  localparam int unsigned CBP_LSB  = CA_LSB + IW;
  localparam int unsigned CC_LSB   = CBP_LSB + IW;
  localparam int unsigned LEN_LSB  = CC_LSB + IW;

  // index modulo MAX_VERTICES: reciprocal multiply, then one correction
  function automatic logic [AW-1:0] wrap_idx(input logic [IW-1:0] v);
    logic [31:0] quo;
    logic [31:0] rem;
    begin
      quo = (32'(v) * 32'(WRAP_RECIP)) >> WRAP_SHIFT;
      rem = 32'(v) - quo * 32'(MAX_VERTICES);
      if (rem >= 32'(MAX_VERTICES)) begin
        rem = rem - 32'(MAX_VERTICES);
      end
      return AW'(rem);
    end
  endfunction

  function automatic logic signed [DW-1:0] sub_c(input logic signed [CB-1:0] a,
                                                 input logic signed [CB-1:0] b);
    begin
      return {a[CB-1], a} - {b[CB-1], b};
    end
  endfunction

  // input fields
  ecl_pkg::mode_e       in_mode;
  logic [IW-1:0]        in_slot, in_lvtx, in_ca, in_cb, in_cc;
  logic [CB-1:0]        in_x, in_y;
  logic [ecl_pkg::LEN_W-1:0] in_len;

  assign in_mode = ecl_pkg::mode_e'(s_axis_tuser_i);
  assign in_slot = s_axis_tdata_i[SLOT_LSB +: IW];
  assign in_x    = s_axis_tdata_i[CX_LSB +: CB];
  assign in_y    = s_axis_tdata_i[CY_LSB +: CB];
  assign in_lvtx = s_axis_tdata_i[LV_LSB +: IW];
  assign in_ca   = s_axis_tdata_i[CA_LSB +: IW];
  assign in_cb   = s_axis_tdata_i[CBP_LSB +: IW];
  assign in_cc   = s_axis_tdata_i[CC_LSB +: IW];
  assign in_len  = s_axis_tdata_i[LEN_LSB +: ecl_pkg::LEN_W];

  ecl_pkg::state_e state_d, state_q;
  ecl_pkg::kind_e  kind_d, kind_q;
  logic [AW-1:0]   pos_d, pos_q;
  logic [AW-1:0]   u_q, v_q, w_q;
  logic [PW-1:0]   len_q;
  logic            area_ok_d, area_ok_q;
  logic            hit_d, hit_q;
  logic            res_d, res_q;
  logic            out_valid_d, out_valid_q;
  logic            out_data_q;

  logic            acc, q_acc;
  logic            issue_en, issue_last, issue_skip, out_load;
  logic            list_we, vtx_we;
  logic [AW-1:0]   list_raddr, list_rdata;
  logic [2*CB-1:0] vtx_rdata;

  ecl_pkg::tag_t   tag_in;
  ecl_pkg::tag_t   tag_q [NSTG];

  logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic signed [CB-1:0] px, py;
  ecl_pkg::cross_flags_t fl1, fl2, fl3;

  assign acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign q_acc = acc && (in_mode == ecl_pkg::MODE_QUERY);

  always_comb begin
    list_we = 1'b0;
    vtx_we  = 1'b0;
    case (in_mode)
      ecl_pkg::MODE_VTX:   vtx_we  = acc;
      ecl_pkg::MODE_LIST:  list_we = acc;
      default: ;
    endcase
  end

  // ---------------- state machine ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ecl_pkg::ST_IDLE: begin
        if (q_acc) state_d = ecl_pkg::ST_ISSUE;
      end
      ecl_pkg::ST_ISSUE: begin
        if (issue_last) state_d = ecl_pkg::ST_DRAIN;
      end
      ecl_pkg::ST_DRAIN: begin
        if (tag_q[NSTG-1].valid && tag_q[NSTG-1].last) state_d = ecl_pkg::ST_HOLD;
      end
      ecl_pkg::ST_HOLD: begin
        if (out_load) state_d = ecl_pkg::ST_IDLE;
      end
      default: state_d = ecl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    issue_en        = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      ecl_pkg::ST_IDLE:  s_axis_tready_o = 1'b1;
      ecl_pkg::ST_ISSUE: issue_en = 1'b1;
      ecl_pkg::ST_HOLD:  out_load = ~out_valid_q | m_axis_tready_i;
      default: ;
    endcase
  end

  // ---------------- read issue ----------------
  always_comb begin
    list_raddr = pos_q;
    issue_last = 1'b0;
    issue_skip = 1'b0;
    case (kind_q)
      ecl_pkg::K_CORNER_A: list_raddr = u_q;
      ecl_pkg::K_CORNER_B: list_raddr = v_q;
      ecl_pkg::K_CORNER_C: list_raddr = w_q;
      ecl_pkg::K_AREA: begin
        // corner c again, run through edge a-b as the area check
        list_raddr = w_q;
        issue_last = (len_q == '0);
      end
      ecl_pkg::K_POINT: begin
        list_raddr = pos_q;
        issue_last = ((PW'(pos_q) + PW'(1)) == len_q);
        issue_skip = (pos_q == u_q) || (pos_q == v_q) || (pos_q == w_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    kind_d = kind_q;
    pos_d  = pos_q;
    if (q_acc) begin
      kind_d = ecl_pkg::K_CORNER_A;
      pos_d  = '0;
    end else if (issue_en) begin
      case (kind_q)
        ecl_pkg::K_CORNER_A: kind_d = ecl_pkg::K_CORNER_B;
        ecl_pkg::K_CORNER_B: kind_d = ecl_pkg::K_CORNER_C;
        ecl_pkg::K_CORNER_C: kind_d = ecl_pkg::K_AREA;
        ecl_pkg::K_AREA: begin
          kind_d = ecl_pkg::K_POINT;
          pos_d  = '0;
        end
        ecl_pkg::K_POINT:    pos_d = pos_q + AW'(1);
        default:             kind_d = ecl_pkg::K_CORNER_A;
      endcase
    end
  end

  always_comb begin
    tag_in.valid = issue_en;
    tag_in.kind  = kind_q;
    tag_in.skip  = issue_skip;
    tag_in.last  = issue_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ecl_pkg::ST_IDLE;
      kind_q      <= ecl_pkg::K_CORNER_A;
      pos_q       <= '0;
      area_ok_q   <= 1'b0;
      hit_q       <= 1'b0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NSTG; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      pos_q       <= pos_d;
      area_ok_q   <= area_ok_d;
      hit_q       <= hit_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      tag_q[0]    <= tag_in;
      for (int i = 1; i < NSTG; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  // query operands, captured at accept
  always_ff @(posedge clk_i) begin
    if (q_acc) begin
      u_q <= wrap_idx(in_ca);
      v_q <= wrap_idx(in_cb);
      w_q <= wrap_idx(in_cc);
      if (32'(in_len) > 32'(MAX_VERTICES)) begin
        len_q <= PW'(MAX_VERTICES);
      end else begin
        len_q <= PW'(in_len);
      end
    end
  end

  // ---------------- memories ----------------
  ecl_store #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW),
    .CW    (CB)
  ) u_store (
    .clk_i        (clk_i),
    .list_we_i    (list_we),
    .list_waddr_i (wrap_idx(in_slot)),
    .list_wdata_i (wrap_idx(in_lvtx)),
    .list_raddr_i (list_raddr),
    .list_rdata_o (list_rdata),
    .vtx_we_i     (vtx_we),
    .vtx_waddr_i  (wrap_idx(in_slot)),
    .vtx_wdata_i  ({in_y, in_x}),
    .vtx_raddr_i  (list_rdata),
    .vtx_rdata_o  (vtx_rdata)
  );

  assign px = vtx_rdata[CB-1:0];
  assign py = vtx_rdata[2*CB-1:CB];

  // corner coordinates land after their list read and the vertex read, both registered
  always_ff @(posedge clk_i) begin
    if (tag_q[1].valid) begin
      case (tag_q[1].kind)
        ecl_pkg::K_CORNER_A: begin
          ax_q <= px;
          ay_q <= py;
        end
        ecl_pkg::K_CORNER_B: begin
          bx_q <= px;
          by_q <= py;
        end
        ecl_pkg::K_CORNER_C: begin
          cx_q <= px;
          cy_q <= py;
        end
        default: ;
      endcase
    end
  end

  // ---------------- edge tests ----------------
  ecl_cross #(.DW(DW)) u_edge_bc (
    .clk_i   (clk_i),
    .p_i     (sub_c(cx_q, bx_q)),
    .q_i     (sub_c(py, by_q)),
    .r_i     (sub_c(cy_q, by_q)),
    .s_i     (sub_c(px, bx_q)),
    .flags_o (fl1)
  );

  ecl_cross #(.DW(DW)) u_edge_ca (
    .clk_i   (clk_i),
    .p_i     (sub_c(ax_q, cx_q)),
    .q_i     (sub_c(py, cy_q)),
    .r_i     (sub_c(ay_q, cy_q)),
    .s_i     (sub_c(px, cx_q)),
    .flags_o (fl2)
  );

  ecl_cross #(.DW(DW)) u_edge_ab (
    .clk_i   (clk_i),
    .p_i     (sub_c(bx_q, ax_q)),
    .q_i     (sub_c(py, ay_q)),
    .r_i     (sub_c(by_q, ay_q)),
    .s_i     (sub_c(px, ax_q)),
    .flags_o (fl3)
  );

  // ---------------- verdict ----------------
  always_comb begin
    area_ok_d = area_ok_q;
    hit_d     = hit_q;
    res_d     = res_q;
    if (q_acc) begin
      area_ok_d = 1'b0;
      hit_d     = 1'b0;
    end
    if (tag_q[NSTG-1].valid) begin
      if (tag_q[NSTG-1].kind == ecl_pkg::K_AREA) begin
        area_ok_d = fl3.gt0;
      end
      if ((tag_q[NSTG-1].kind == ecl_pkg::K_POINT) && !tag_q[NSTG-1].skip &&
          fl1.ge0 && fl2.ge0 && fl3.ge0) begin
        hit_d = 1'b1;
      end
      if (tag_q[NSTG-1].last) begin
        res_d = area_ok_d & ~hit_d;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(ecl_pkg::OUT_W-1){1'b0}}, out_data_q};

endmodule

// ----- hw/rtl/ecl_checker.sv -----
// ----------------------------------------------------------------------------
// ecl_checker
// Port level checks of the polygon ear test block, bound to the top level.
// ----------------------------------------------------------------------------
module ecl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_tvalid_i,
  input logic                      s_tready_i,
  input logic [1:0]                s_tuser_i,
  input logic                      m_tvalid_i,
  input logic                      m_tready_i,
  input logic [ecl_pkg::OUT_W-1:0] m_tdata_i
);

  logic q_acc, ld_acc;

  assign q_acc  = s_tvalid_i && s_tready_i && (s_tuser_i == ecl_pkg::MODE_QUERY);
  assign ld_acc = s_tvalid_i && s_tready_i && (s_tuser_i != ecl_pkg::MODE_QUERY);

  // a query holds off further input items
  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_acc |=> !s_tready_i)
    else $error("input still ready after a query item");

  // load items never make the block busy
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_acc |=> s_tready_i)
    else $error("block went busy after a load item");

  // a result never shows up right after a query is taken
  a_no_instant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_acc |=> !$rose(m_tvalid_i))
    else $error("result appeared in the cycle after a query item");

  // a stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i)))
    else $error("stalled result changed or dropped");

endmodule

bind polygon_ear_test_top ecl_checker u_ecl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tuser_i  (s_axis_tuser_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

// ----- tb/tb_polygon_ear_test_top.sv -----
// ----------------------------------------------------------------------------
// tb_polygon_ear_test_top
// Self-checking bench for the polygon ear test block. Small polygons are
// loaded into the vertex memory and the active list. Corners are queried,
// with some ear clipping along the way. One pass fills the whole list.
// Each query answer is predicted with exact integer cross products and
// compared in order with what leaves the result stream.
// ----------------------------------------------------------------------------
module tb_polygon_ear_test_top;
  import ecl_pkg::*;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned DEPTH      = 256;
  localparam int unsigned IN_W       =
    (((5 * IDX_W + LEN_W + 2 * COORD_BITS) + 7) / 8) * 8;
  localparam logic [1:0] MODE_NONE   = 2'd3;  // unused mode, ignored by the block
  localparam logic signed [COORD_BITS-1:0] C_MIN = 24'sh800000;
  localparam logic signed [COORD_BITS-1:0] C_MAX = 24'sh7fffff;
  localparam int unsigned N_ITEMS    = 1700;

  typedef struct packed {
    logic [1:0]                   mode;
    logic [IDX_W-1:0]             slot;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [IDX_W-1:0]             lv;
    logic [IDX_W-1:0]             ca;
    logic [IDX_W-1:0]             cb;
    logic [IDX_W-1:0]             cc;
    logic [LEN_W-1:0]             len;
  } ear_item_t;

  class ear_scoreboard;
    longint     xs[DEPTH];
    longint     ys[DEPTH];
    bit [7:0]   ring[DEPTH];
    bit         expected_ears[$];
    int         errors;

    // (u - o) x (v - o), exact in 64 bits for 24-bit coordinates
    function longint turn(longint ox, longint oy, longint ux, longint uy,
                          longint vx, longint vy);
      return (ux - ox) * (vy - oy) - (uy - oy) * (vx - ox);
    endfunction

    function bit ear_verdict(int u, int v, int w, int len);
      int a;
      int b;
      int c;
      int p;
      int n;
      a = ring[u];
      b = ring[v];
      c = ring[w];
      if (turn(xs[a], ys[a], xs[b], ys[b], xs[c], ys[c]) <= 0) return 1'b0;
      n = (len > DEPTH) ? DEPTH : len;
      for (int pos = 0; pos < n; pos++) begin
        if (pos == u || pos == v || pos == w) continue;
        p = ring[pos];
        // inside or on the triangle closes the ear
        if (turn(xs[b], ys[b], xs[c], ys[c], xs[p], ys[p]) >= 0 &&
            turn(xs[c], ys[c], xs[a], ys[a], xs[p], ys[p]) >= 0 &&
            turn(xs[a], ys[a], xs[b], ys[b], xs[p], ys[p]) >= 0)
          return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(ear_item_t it);
      case (it.mode)
        MODE_VTX: begin
          xs[it.slot] = longint'(it.x);
          ys[it.slot] = longint'(it.y);
        end
        MODE_LIST: ring[it.slot] = it.lv;
        MODE_QUERY: expected_ears.push_back(ear_verdict(int'(it.ca), int'(it.cb),
                                                        int'(it.cc), int'(it.len)));
        default: ;
      endcase
    endfunction

    function void check_result(logic got);
      bit want;
      if (expected_ears.size() == 0) begin
        $error("is_ear: no query pending, expected none, actual %0d", got);
        errors++;
        return;
      end
      want = expected_ears.pop_front();
      if (got !== want) begin
        $error("is_ear mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_ears.size();
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni  = 1'b0;
  logic            s_valid = 1'b0;
  logic [IN_W-1:0] s_data  = '0;
  logic [1:0]      s_user  = '0;
  logic            m_ready = 1'b0;
  logic            s_axis_tready_o;
  logic            m_axis_tvalid_o;
  logic [OUT_W-1:0] m_axis_tdata_o;

  ear_scoreboard   sb = new();
  bit              quiet = 1'b0;
  int              n_loads = 0;
  // what has been written so far, so that no query reads a blank entry
  bit              vtx_ok[DEPTH];
  bit              list_ok[DEPTH];
  logic [7:0]      list_mirror[DEPTH];

  polygon_ear_test_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls except in the quiet stretch
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_ready) sb.check_result(m_axis_tdata_o[0]);
      m_ready <= quiet || ($urandom_range(99) >= 23);
    end
  end

  function automatic ear_item_t random_item();
    ear_item_t it;
    it.mode = MODE_NONE;
    it.slot = IDX_W'($urandom);
    it.x    = COORD_BITS'($urandom);
    it.y    = COORD_BITS'($urandom);
    it.lv   = IDX_W'($urandom);
    it.ca   = IDX_W'($urandom);
    it.cb   = IDX_W'($urandom);
    it.cc   = IDX_W'($urandom);
    it.len  = LEN_W'($urandom);
    return it;
  endfunction

  function automatic int valid_prefix();
    int l;
    l = 0;
    while (l < DEPTH && list_ok[l] && vtx_ok[list_mirror[l]]) l++;
    return l;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord(int style);
    case (style)
      0: return COORD_BITS'((int'($urandom_range(0, 16)) - 8) * 256);
      1: return COORD_BITS'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          3: return COORD_BITS'(1);
          default: return COORD_BITS'(-1);
        endcase
      end
    endcase
  endfunction

  task automatic send_item(input ear_item_t it);
    if (!quiet) begin
      while ($urandom_range(99) < 23) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= IN_W'({it.len, it.cc, it.cb, it.ca, it.lv, it.y, it.x, it.slot});
    s_user  <= it.mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(it);
    case (it.mode)
      MODE_VTX: vtx_ok[it.slot] = 1'b1;
      MODE_LIST: begin
        list_ok[it.slot]     = 1'b1;
        list_mirror[it.slot] = it.lv;
      end
      default: ;
    endcase
    if (it.mode != MODE_NONE) n_loads++;
  endtask

  task automatic put_vertex(input int slot, input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y);
    ear_item_t it;
    it      = random_item();
    it.mode = MODE_VTX;
    it.slot = IDX_W'(slot);
    it.x    = x;
    it.y    = y;
    send_item(it);
  endtask

  task automatic put_entry(input int pos, input int vtx);
    ear_item_t it;
    it      = random_item();
    it.mode = MODE_LIST;
    it.slot = IDX_W'(pos);
    it.lv   = IDX_W'(vtx);
    send_item(it);
  endtask

  task automatic ask(input int a, input int b, input int c, input int len);
    ear_item_t it;
    it      = random_item();
    it.mode = MODE_QUERY;
    it.ca   = IDX_W'(a);
    it.cb   = IDX_W'(b);
    it.cc   = IDX_W'(c);
    it.len  = LEN_W'(len);
    send_item(it);
  endtask

  task automatic junk();
    send_item(random_item());
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic polygon_session();
    int dx[8];
    int dy[8];
    int vs[12];
    int shape;
    int style;
    int n;
    int poly;
    int m;
    int extra;
    int base;
    int stride;
    int ox;
    int oy;
    int s;
    int i;
    int r;
    int pre;
    int len;
    int v;
    dx = '{3, 2, 0, -2, -3, -2, 0, 2};
    dy = '{0, 2, 3, 2, 0, -2, -3, -2};
    shape  = $urandom_range(0, 9);
    style  = $urandom_range(0, 2);
    n      = (shape < 5) ? $urandom_range(3, 8) : $urandom_range(3, 10);
    base   = $urandom_range(0, 255);
    stride = $urandom_range(0, 127) * 2 + 1;
    ox     = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    oy     = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    s      = 1 << $urandom_range(0, 14);
    extra  = 0;
    // convex counter-clockwise outline, or loose points
    for (int k = 0; k < n; k++) begin
      vs[k] = (base + k * stride) % DEPTH;
      if (shape < 5)
        put_vertex(vs[k], COORD_BITS'(ox + dx[k] * s), COORD_BITS'(oy + dy[k] * s));
      else
        put_vertex(vs[k], rand_coord(style), rand_coord(style));
    end
    if (shape < 5 && $urandom_range(0, 2) == 0) begin
      vs[n] = (base + n * stride) % DEPTH;
      put_vertex(vs[n], COORD_BITS'(ox + s), COORD_BITS'(oy + s));
      extra = 1;
    end
    for (int k = 0; k < n + extra; k++) begin
      v = vs[k];
      if (shape >= 5 && k > 0 && $urandom_range(0, 9) == 0) v = vs[k - 1];
      put_entry(k, v);
    end
    poly = n;
    m    = n + extra;
    repeat ($urandom_range(2, 5)) begin
      pre = valid_prefix();
      i   = $urandom_range(0, poly - 1);
      r   = $urandom_range(0, 19);
      len = $urandom_range(0, 19);
      if (len < 16) len = m;
      else if (len < 18) len = $urandom_range(0, m);
      else len = $urandom_range(0, (pre == DEPTH) ? 511 : pre);
      if (r < 13) ask(i, (i + 1) % poly, (i + 2) % poly, len);
      else if (r < 16) ask((i + 2) % poly, (i + 1) % poly, i, len);
      else if (r < 18)
        ask($urandom_range(0, pre - 1), $urandom_range(0, pre - 1),
            $urandom_range(0, pre - 1), len);
      else ask(i, i, (i + 1) % poly, len);
      if ($urandom_range(0, 4) == 0) junk();
    end
    // clip ears off the outline and test the new corner
    while (poly > 3 && $urandom_range(0, 1) == 1) begin
      i = $urandom_range(1, poly - 2);
      for (int p = i; p < m - 1; p++) put_entry(p, list_mirror[p + 1]);
      poly--;
      m--;
      ask(i - 1, i % poly, (i + 1) % poly, m);
    end
    if ($urandom_range(0, 3) == 0)
      put_vertex($urandom_range(0, 255), COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  task automatic fill_everything();
    int a;
    for (int k = 0; k < DEPTH; k++) put_vertex(k, rand_coord(1), rand_coord(1));
    for (int k = 0; k < DEPTH; k++) put_entry(k, $urandom_range(0, 255));
    repeat (24) begin
      a = $urandom_range(0, 255);
      if ($urandom_range(0, 1) == 1)
        ask(a, (a + 1) % DEPTH, (a + 2) % DEPTH, $urandom_range(0, 8));
      else
        ask($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(200, 511));
    end
  endtask

  initial begin
    int session_no;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unit triangle, a point inside, a point on an edge, extreme corners
    put_vertex(0, 0, 0);
    put_vertex(1, 256, 0);
    put_vertex(2, 0, 256);
    put_vertex(3, 64, 64);
    put_vertex(4, 128, 0);
    put_vertex(5, C_MIN, C_MIN);
    put_vertex(6, C_MAX, C_MIN);
    put_vertex(7, C_MAX, C_MAX);
    put_vertex(255, C_MIN, C_MAX);
    put_entry(0, 0);
    put_entry(1, 1);
    put_entry(2, 2);
    ask(0, 1, 2, 3);
    ask(2, 1, 0, 3);
    ask(0, 0, 1, 3);
    put_entry(3, 3);
    ask(0, 1, 2, 4);
    put_entry(3, 4);
    ask(0, 1, 2, 4);
    put_entry(4, 5);
    put_entry(5, 6);
    put_entry(6, 7);
    put_entry(7, 255);
    ask(4, 5, 6, 0);
    ask(4, 5, 6, 8);
    junk();

    session_no = 0;
    while (n_loads < N_ITEMS) begin
      if (session_no == 12) begin
        drain();
        fill_everything();
        drain();
      end
      quiet = (session_no >= 20 && session_no < 32);
      polygon_session();
      session_no++;
    end
    quiet = 1'b0;
    drain();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- polygon_ear_test_top.f -----
hw/rtl/ecl_pkg.sv
hw/rtl/ecl_cross.sv
hw/rtl/ecl_store.sv
hw/rtl/polygon_ear_test_top.sv
hw/rtl/ecl_checker.sv
tb/tb_polygon_ear_test_top.sv
